// ===== sv/twws_pkg.sv =====
`timescale 1ns / 1ps
// twws_pkg: constants, state encoding and result layout for track_wind_wave_stats.
// No dependencies.
package twws_pkg;

	localparam int unsigned MAX_POINTS = 65536;
	localparam int unsigned CNT_W      = 17;
	localparam int unsigned SUM_W      = 32;
	localparam int unsigned SPEED_W    = 16;
	localparam int unsigned ANGLE_W    = 16;
	localparam int unsigned WAVE_W     = 12;
	localparam int unsigned DIV_W      = 33;
	localparam int unsigned STEP_W     = 6;

	localparam logic [CNT_W-1:0]   CNT_MAX      = CNT_W'(MAX_POINTS);
	localparam logic [ANGLE_W-1:0] ANGLE_FULL   = 16'd36000;
	localparam logic [ANGLE_W-1:0] ANGLE_HALF   = 16'd18000;
	localparam logic [ANGLE_W-1:0] ANGLE_UPWIND = 16'd6000;
	localparam logic [STEP_W-1:0]  DIV_LAST     = STEP_W'(DIV_W - 1);
	localparam logic [CNT_W-1:0]   SHARE_MAX    = 17'd65536;

	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned OUT_DATA_W = 80;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MEAN  = 4'b0010,
		ST_SHARE = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	// packed from the highest bit down; mean_wind lands in the lowest bits
	typedef struct packed {
		logic [CNT_W-1:0]   point_count;
		logic [CNT_W-1:0]   upwind_share;
		logic               wave_seen;
		logic [WAVE_W-1:0]  peak_wave;
		logic [SPEED_W-1:0] peak_wind;
		logic [SPEED_W-1:0] mean_wind;
	} result_t;

endpackage

// ===== sv/track_wind_wave_stats.sv =====
`timescale 1ns / 1ps
// track_wind_wave_stats: per-point wind/wave statistics over a track.
// An ordinary point is absorbed on acceptance, one transaction per cycle while the block is idle.
// A last point runs the divider for the mean, then for the share, then the output state, which
// registers the result; the next transaction is taken only once the block is back in idle.
// The span is set by one shared restoring divider (one quotient bit per cycle) run for mean and
// share. Input is not ready while the divider runs or a result waits. Async active-low reset.
// Depends on twws_pkg.
module track_wind_wave_stats (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [15:0] wind_speed, [31:16] wind_direction, [47:32] course, [59:48] wave_height
	input  logic [twws_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [15:0] mean_wind, [31:16] peak_wind, [43:32] peak_wave, [44] wave_seen,
	// [61:45] upwind_share, [78:62] point_count
	output logic [twws_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	twws_pkg::state_t state_q;

	logic [twws_pkg::SUM_W-1:0]   sum_q;
	logic [twws_pkg::SPEED_W-1:0] speed_peak_q;
	logic [twws_pkg::WAVE_W-1:0]  wave_peak_q;
	logic                         wave_flag_q;
	logic [twws_pkg::CNT_W-1:0]   upwind_q;
	logic [twws_pkg::CNT_W-1:0]   points_q;

	logic [twws_pkg::DIV_W-1:0]   dq_q;
	logic [twws_pkg::CNT_W-1:0]   rem_q;
	logic [twws_pkg::STEP_W-1:0]  step_q;
	logic [twws_pkg::SPEED_W-1:0] mean_q;
	logic [twws_pkg::CNT_W-1:0]   share_q;
	twws_pkg::result_t            res_q;
	logic                         out_valid_q;

	logic [twws_pkg::SPEED_W-1:0] speed;
	logic [twws_pkg::ANGLE_W-1:0] dir, cog, diff, dmod, dfold;
	logic [twws_pkg::WAVE_W-1:0]  wave;
	logic                         upwind;
	logic                         accept;
	logic [twws_pkg::SUM_W:0]     sum_ext;
	logic [twws_pkg::SUM_W-1:0]   sum_nxt;
	logic [twws_pkg::CNT_W-1:0]   upwind_nxt, points_nxt;

	logic [twws_pkg::CNT_W:0]     trial;
	logic                         ge;
	logic [twws_pkg::CNT_W:0]     trial_sub;
	logic [twws_pkg::CNT_W-1:0]   rem_nxt;
	logic [twws_pkg::DIV_W-1:0]   dq_nxt;
	logic                         div_done;
	logic                         out_free;

	assign speed = s_axis_tdata[15:0];
	assign dir   = s_axis_tdata[31:16];
	assign cog   = s_axis_tdata[47:32];
	assign wave  = s_axis_tdata[59:48];

	assign s_axis_tready = (state_q == twws_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		diff  = (dir > cog) ? (dir - cog) : (cog - dir);
		dmod  = (diff >= twws_pkg::ANGLE_FULL) ? (diff - twws_pkg::ANGLE_FULL) : diff;
		dfold = (dmod > twws_pkg::ANGLE_HALF) ? (twws_pkg::ANGLE_FULL - dmod) : dmod;
		upwind = (dfold < twws_pkg::ANGLE_UPWIND);
	end

	always_comb begin
		sum_ext    = {1'b0, sum_q} + {{(twws_pkg::SUM_W + 1 - twws_pkg::SPEED_W){1'b0}}, speed};
		sum_nxt    = sum_ext[twws_pkg::SUM_W] ? '1 : sum_ext[twws_pkg::SUM_W-1:0];
		points_nxt = (points_q < twws_pkg::CNT_MAX) ? (points_q + 1'b1) : points_q;
		upwind_nxt = (upwind && (upwind_q < twws_pkg::CNT_MAX)) ? (upwind_q + 1'b1) : upwind_q;
	end

	// shared restoring divider step, divisor is the point count
	always_comb begin
		trial     = {rem_q, dq_q[twws_pkg::DIV_W-1]};
		ge        = (trial >= {1'b0, points_q});
		trial_sub = trial - {1'b0, points_q};
		rem_nxt   = ge ? trial_sub[twws_pkg::CNT_W-1:0] : trial[twws_pkg::CNT_W-1:0];
		dq_nxt    = {dq_q[twws_pkg::DIV_W-2:0], ge};
		div_done  = (step_q == twws_pkg::DIV_LAST);
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= twws_pkg::ST_IDLE;
			sum_q        <= '0;
			speed_peak_q <= '0;
			wave_peak_q  <= '0;
			wave_flag_q  <= 1'b0;
			upwind_q     <= '0;
			points_q     <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != twws_pkg::ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				twws_pkg::ST_IDLE: begin
					if (accept) begin
						sum_q    <= sum_nxt;
						upwind_q <= upwind_nxt;
						points_q <= points_nxt;
						if (speed > speed_peak_q) begin
							speed_peak_q <= speed;
						end
						if (wave != '0) begin
							wave_flag_q <= 1'b1;
						end
						if (wave > wave_peak_q) begin
							wave_peak_q <= wave;
						end
						if (s_axis_tlast) begin
							step_q  <= '0;
							state_q <= twws_pkg::ST_MEAN;
						end
					end
				end
				twws_pkg::ST_MEAN: begin
					step_q <= div_done ? '0 : step_q + 1'b1;
					if (div_done) begin
						state_q <= twws_pkg::ST_SHARE;
					end
				end
				twws_pkg::ST_SHARE: begin
					step_q <= div_done ? '0 : step_q + 1'b1;
					if (div_done) begin
						state_q <= twws_pkg::ST_OUT;
					end
				end
				twws_pkg::ST_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						sum_q        <= '0;
						speed_peak_q <= '0;
						wave_peak_q  <= '0;
						wave_flag_q  <= 1'b0;
						upwind_q     <= '0;
						points_q     <= '0;
						state_q      <= twws_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= twws_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			twws_pkg::ST_IDLE: begin
				dq_q  <= {1'b0, sum_nxt};
				rem_q <= '0;
			end
			twws_pkg::ST_MEAN: begin
				if (div_done) begin
					mean_q <= (|dq_nxt[twws_pkg::DIV_W-1:twws_pkg::SPEED_W]) ?
						'1 : dq_nxt[twws_pkg::SPEED_W-1:0];
					dq_q   <= {upwind_q, {twws_pkg::SPEED_W{1'b0}}};
					rem_q  <= '0;
				end else begin
					dq_q  <= dq_nxt;
					rem_q <= rem_nxt;
				end
			end
			twws_pkg::ST_SHARE: begin
				if (div_done) begin
					share_q <= (dq_nxt > {{(twws_pkg::DIV_W - twws_pkg::CNT_W){1'b0}},
						twws_pkg::SHARE_MAX}) ? twws_pkg::SHARE_MAX :
						dq_nxt[twws_pkg::CNT_W-1:0];
				end
				dq_q  <= dq_nxt;
				rem_q <= rem_nxt;
			end
			twws_pkg::ST_OUT: begin
				if (out_free) begin
					res_q.mean_wind    <= mean_q;
					res_q.peak_wind    <= speed_peak_q;
					res_q.peak_wave    <= wave_peak_q;
					res_q.wave_seen    <= wave_flag_q;
					res_q.upwind_share <= share_q;
					res_q.point_count  <= points_q;
				end
			end
			default: begin
				rem_q <= '0;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, res_q};

endmodule

// ===== sv/twws_checker.sv =====
`timescale 1ns / 1ps
// twws_checker: port-level assertions for track_wind_wave_stats, bound to the top level.
// Depends on track_wind_wave_stats ports and twws_pkg.
module twws_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            s_axis_tlast,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [twws_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction dropped or changed while stalled");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input ready right after a last transaction");

	a_wave_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[44] || (m_axis_tdata[43:32] == 12'd0))
		else $error("peak wave without wave seen");

	a_share_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[61] && (m_axis_tdata[60:45] != 16'd0)) &&
			(m_axis_tdata[78:62] != 17'd0))
		else $error("upwind share or point count out of range");

	a_mean_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:0] <= m_axis_tdata[31:16])
		else $error("mean wind above peak wind");

endmodule

bind track_wind_wave_stats twws_checker u_twws_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
